/* sv/lrc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lrc_pkg;

  localparam int CAP_W = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
  localparam int IN_W = 64;
  localparam int OUT_W = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SWEEP,
    ST_COMMIT
  } lrc_state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic sweep;
    logic decide;
    logic commit;
  } lrc_cmd_t;

  typedef struct packed {
    logic step_done;
    logic out_free;
  } lrc_stat_t;

endpackage

`default_nettype wire

/* sv/lru_cache_lookup.sv */
`timescale 1ns / 1ps
`default_nettype none

// Fully associative LRU cache of query keys. Each request on the slave stream
// carries one key in tdata; the master stream returns one item per request
// whose tdata bit 0 is the hit flag. Keys and recency ranks live in single-port
// read memories, so a lookup scans the F filled entries once to compare keys and
// locate the least recent entry, then sweeps them again to age the ranks, one
// request at a time. A finished result sits in an output register and the next
// request is taken while it waits. The user must write the capacity register on
// the cfg channel only while the block is idle; the block itself does not enforce
// this. Zero acts as one and values above ENTRIES act as ENTRIES. The cache starts
// empty after reset and needs no clearing pass.
module lru_cache_lookup
  import lrc_pkg::*;
#(
  parameter int ENTRIES  = 64,
  parameter int KEY_BITS = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  wire logic [IN_W-1:0]  s_axis_tdata_i,   // [63:0] key
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  output logic [OUT_W-1:0]      m_axis_tdata_o,   // [0] hit, [7:1] zero
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CAP_W-1:0] cfg_data_i
);

  lrc_cmd_t         cmd;
  lrc_stat_t        stat;
  logic [CAP_W-1:0] cap_q;
  logic             out_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  lrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lrc_datapath #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .key_i       (s_axis_tdata_i),
    .cap_i       (cap_q),
    .out_ready_i (m_axis_tready_i),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid_o),
    .out_hit_o   (out_hit)
  );

  assign m_axis_tdata_o = {{(OUT_W-1){1'b0}}, out_hit};

endmodule

`default_nettype wire

/* sv/lrc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module lrc_ctrl
  import lrc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire lrc_stat_t stat_i,
  output lrc_cmd_t       cmd_o
);

  lrc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat_i.step_done) state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (stat_i.step_done) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.step   = 1'b1;
        cmd_o.decide = stat_i.step_done;
      end
      ST_SWEEP: begin
        cmd_o.step  = 1'b1;
        cmd_o.sweep = 1'b1;
      end
      ST_COMMIT: begin
        cmd_o.commit = stat_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/lrc_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module lrc_datapath
  import lrc_pkg::*;
#(
  parameter int ENTRIES  = 64,
  parameter int KEY_BITS = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire lrc_cmd_t         cmd_i,
  input  wire logic [IN_W-1:0]  key_i,
  input  wire logic [CAP_W-1:0] cap_i,
  input  wire logic             out_ready_i,
  output lrc_stat_t             stat_o,
  output logic                  out_valid_o,
  output logic                  out_hit_o
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int FILL_W = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;

  logic [KEY_BITS-1:0] key_mem [ENTRIES];
  logic [IDX_W-1:0]    rank_mem [ENTRIES];

  logic [KEY_BITS-1:0] key_q;
  logic [KEY_BITS-1:0] key_rd_q;
  logic [IDX_W-1:0]    rank_rd_q;

  logic [FILL_W-1:0] filled_q, filled_d;
  logic [FILL_W-1:0] cnt_q, cnt_d;
  logic              pend_q, pend_d;
  logic [IDX_W-1:0]  pend_idx_q, pend_idx_d;
  logic              hit_found_q, hit_found_d;
  logic [IDX_W-1:0]  hit_idx_q, hit_idx_d;
  logic [IDX_W-1:0]  hit_rank_q, hit_rank_d;
  logic [IDX_W-1:0]  vic_idx_q, vic_idx_d;
  logic [FILL_W-1:0] thresh_q, thresh_d;
  logic [IDX_W-1:0]  target_q, target_d;
  logic              grow_q, grow_d;
  logic              out_valid_q, out_valid_d;
  logic              out_hit_q;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              rank_we;
  logic [IDX_W-1:0]  rank_waddr;
  logic [IDX_W-1:0]  rank_wdata;
  logic              key_we;
  logic [FILL_W-1:0] fill_m1;
  logic [CMP_W-1:0]  cap_ext;
  logic [CMP_W-1:0]  eff_cap;
  logic              can_grow;

  assign rd_en   = cmd_i.step && (cnt_q < filled_q);
  assign rd_addr = cnt_q[IDX_W-1:0];
  assign fill_m1 = FILL_W'(filled_q - 1'b1);
  assign cap_ext = CMP_W'(cap_i);

  always_comb begin
    if (cap_i == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign can_grow = CMP_W'(filled_q) < eff_cap;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      key_rd_q  <= key_mem[rd_addr];
      rank_rd_q <= rank_mem[rd_addr];
    end
    if (rank_we) begin
      rank_mem[rank_waddr] <= rank_wdata;
    end
    if (key_we) begin
      key_mem[target_q] <= key_q;
    end
  end

  always_comb begin
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    hit_found_d = hit_found_q;
    hit_idx_d   = hit_idx_q;
    hit_rank_d  = hit_rank_q;
    vic_idx_d   = vic_idx_q;
    thresh_d    = thresh_q;
    target_d    = target_q;
    grow_d      = grow_q;
    filled_d    = filled_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rank_we     = 1'b0;
    rank_waddr  = pend_idx_q;
    rank_wdata  = IDX_W'(rank_rd_q + 1'b1);
    key_we      = 1'b0;

    if (cmd_i.load) begin
      cnt_d       = '0;
      pend_d      = 1'b0;
      hit_found_d = 1'b0;
    end

    if (cmd_i.step) begin
      pend_d = rd_en;
      if (rd_en) begin
        cnt_d      = FILL_W'(cnt_q + 1'b1);
        pend_idx_d = cnt_q[IDX_W-1:0];
      end
      if (pend_q && !cmd_i.sweep) begin
        if (key_rd_q == key_q && !hit_found_q) begin
          hit_found_d = 1'b1;
          hit_idx_d   = pend_idx_q;
          hit_rank_d  = rank_rd_q;
        end
        if (rank_rd_q == fill_m1[IDX_W-1:0]) begin
          vic_idx_d = pend_idx_q;
        end
      end
      if (pend_q && cmd_i.sweep) begin
        rank_we = (pend_idx_q != target_q) && (FILL_W'(rank_rd_q) < thresh_q);
      end
    end

    if (cmd_i.decide) begin
      cnt_d  = '0;
      pend_d = 1'b0;
      grow_d = !hit_found_q && can_grow;
      if (hit_found_q) begin
        thresh_d = FILL_W'(hit_rank_q);
        target_d = hit_idx_q;
      end else if (can_grow) begin
        thresh_d = filled_q;
        target_d = filled_q[IDX_W-1:0];
      end else begin
        thresh_d = fill_m1;
        target_d = vic_idx_q;
      end
    end

    if (cmd_i.commit) begin
      rank_we     = 1'b1;
      rank_waddr  = target_q;
      rank_wdata  = '0;
      key_we      = !hit_found_q;
      out_valid_d = 1'b1;
      if (grow_q) filled_d = FILL_W'(filled_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q    <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      hit_found_q <= 1'b0;
      grow_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      filled_q    <= filled_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      hit_found_q <= hit_found_d;
      grow_q      <= grow_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) key_q <= key_i[KEY_BITS-1:0];
    if (cmd_i.commit) out_hit_q <= hit_found_q;
    pend_idx_q <= pend_idx_d;
    hit_idx_q  <= hit_idx_d;
    hit_rank_q <= hit_rank_d;
    vic_idx_q  <= vic_idx_d;
    thresh_q   <= thresh_d;
    target_q   <= target_d;
  end

  assign stat_o.step_done = (cnt_q == filled_q) && !pend_q;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign out_hit_o        = out_hit_q;

endmodule

`default_nettype wire

/* sv/lrc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module lrc_checker
  import lrc_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid_i,
  input wire logic             s_axis_tready_o,
  input wire logic             m_axis_tvalid_o,
  input wire logic             m_axis_tready_i,
  input wire logic [OUT_W-1:0] m_axis_tdata_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken while a lookup is in flight");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[OUT_W-1:1] == '0)
    else $error("result padding not zero");

endmodule

bind lru_cache_lookup lrc_checker u_lrc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
